[hw/rtl/bstt_pkg.sv]
// Shared types and constants for the bounded score transposition table.
`default_nettype none

package bstt_pkg;

    localparam int INDEX_BITS    = 12;
    localparam int SCORE_BITS    = 16;
    localparam int DEPTH_BITS    = 6;
    localparam int TABLE_ENTRIES = 1 << INDEX_BITS;

    // Fixed field widths of the channels
    localparam int KEY_W      = 64;
    localparam int IN_DEPTH_W = 6;
    localparam int IN_SCORE_W = 16;
    localparam int FLAG_W     = 2;
    localparam int KIND_W     = 2;

    // Compare widths wide enough for every legal parameter value
    localparam int WIDE_W      = 33;
    localparam int DEPTH_CMP_W = 9;

    localparam logic signed [WIDE_W-1:0] SCORE_MAX =
        WIDE_W'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] SCORE_MIN =
        WIDE_W'(-(64'sd1 <<< (SCORE_BITS - 1)));
    localparam logic [DEPTH_CMP_W-1:0] DEPTH_MAX =
        DEPTH_CMP_W'((1 << DEPTH_BITS) - 1);

    localparam logic ACT_PROBE = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_EMPTY = 2'd0,
        KIND_EXACT = 2'd1,
        KIND_LOWER = 2'd2,
        KIND_UPPER = 2'd3
    } kind_t;

    typedef struct packed {
        logic                         action;
        logic [KEY_W-1:0]             position_key;
        logic [IN_DEPTH_W-1:0]        search_depth;
        logic signed [IN_SCORE_W-1:0] alpha_bound;
        logic signed [IN_SCORE_W-1:0] beta_bound;
        logic signed [IN_SCORE_W-1:0] store_value;
        logic [FLAG_W-1:0]            store_flag;
    } in_item_t;

    typedef struct packed {
        logic                         hit;
        logic signed [IN_SCORE_W-1:0] hit_value;
    } out_item_t;

    typedef struct packed {
        kind_t                        kind;
        logic [KEY_W-1:0]             key;
        logic [DEPTH_BITS-1:0]        depth;
        logic signed [SCORE_BITS-1:0] score;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[hw/rtl/bounded_score_transposition_table.sv]
// Top level: direct-mapped, always-replace transposition table.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------
//  in      | input     | in_valid / in_ready | in_data  (in_item_t)
//  out     | output    | out_valid/out_ready | out_data (out_item_t)
//
// One item per cycle while in_ready is high. A store writes the table RAM in its
// transfer cycle and yields nothing; a probe issues its RAM read at the transfer
// edge, is checked in the next cycle and, unless stalled, registered, which raises
// out_valid. After reset a clearing pass writes all TABLE_ENTRIES (4096) entries
// with in_ready low. A stalled result holds the probe stage, which holds in.
`default_nettype none

module bounded_score_transposition_table (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bstt_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bstt_pkg::out_item_t     out_data
);

    // Clearing pass
    logic                              clearing_reg, clearing_next;
    logic [bstt_pkg::INDEX_BITS-1:0]   clr_idx_reg, clr_idx_next;

    // Probe stage (waits for RAM read data)
    logic                              p1_valid_reg, p1_valid_next;
    logic [bstt_pkg::KEY_W-1:0]        p1_key_reg;
    logic [bstt_pkg::IN_DEPTH_W-1:0]   p1_depth_reg;
    logic signed [bstt_pkg::IN_SCORE_W-1:0] p1_alpha_reg;
    logic signed [bstt_pkg::IN_SCORE_W-1:0] p1_beta_reg;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    bstt_pkg::out_item_t               out_data_reg, out_data_next;

    logic                              stall;
    logic                              accept;
    logic                              accept_probe;
    logic                              accept_store;
    logic                              out_load;

    logic                              ram_we;
    logic [bstt_pkg::INDEX_BITS-1:0]   ram_waddr;
    bstt_pkg::entry_t                  ram_wdata;
    bstt_pkg::entry_t                  store_entry;
    bstt_pkg::entry_t                  rd_entry;
    logic [bstt_pkg::ENTRY_W-1:0]      ram_rdata;

    logic signed [bstt_pkg::WIDE_W-1:0] value_ext;
    logic [bstt_pkg::DEPTH_CMP_W-1:0]   store_depth_ext;
    logic signed [bstt_pkg::WIDE_W-1:0] rd_score_ext;
    logic signed [bstt_pkg::WIDE_W-1:0] alpha_ext;
    logic signed [bstt_pkg::WIDE_W-1:0] beta_ext;
    logic                               usable;
    logic                               hit;

    // ---------------- handshake ----------------
    assign stall        = p1_valid_reg && out_valid_reg && !out_ready;
    assign in_ready     = !clearing_reg && !stall;
    assign accept       = in_valid && in_ready;
    assign accept_probe = accept && (in_data.action == bstt_pkg::ACT_PROBE);
    assign accept_store = accept && (in_data.action == bstt_pkg::ACT_STORE);
    assign out_load     = p1_valid_reg && !stall;

    // ---------------- store entry build ----------------
    always_comb
    begin
        value_ext       = bstt_pkg::WIDE_W'($signed(in_data.store_value));
        store_depth_ext = bstt_pkg::DEPTH_CMP_W'(in_data.search_depth);

        store_entry.key = in_data.position_key;
        // flag three wraps to the empty kind
        store_entry.kind = bstt_pkg::kind_t'(bstt_pkg::KIND_W'(in_data.store_flag + 2'd1));

        if (store_depth_ext > bstt_pkg::DEPTH_MAX)
        begin
            store_entry.depth = bstt_pkg::DEPTH_BITS'(bstt_pkg::DEPTH_MAX);
        end
        else
        begin
            store_entry.depth = bstt_pkg::DEPTH_BITS'(store_depth_ext);
        end

        if (value_ext > bstt_pkg::SCORE_MAX)
        begin
            store_entry.score = bstt_pkg::SCORE_BITS'(bstt_pkg::SCORE_MAX);
        end
        else if (value_ext < bstt_pkg::SCORE_MIN)
        begin
            store_entry.score = bstt_pkg::SCORE_BITS'(bstt_pkg::SCORE_MIN);
        end
        else
        begin
            store_entry.score = bstt_pkg::SCORE_BITS'(value_ext);
        end
    end

    // RAM write port: clearing pass owns it until done
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = accept_store;
            ram_waddr = in_data.position_key[bstt_pkg::INDEX_BITS-1:0];
            ram_wdata = store_entry;
        end
    end

    bstt_ram #(
        .WIDTH (bstt_pkg::ENTRY_W),
        .DEPTH (bstt_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept_probe),
        .raddr (in_data.position_key[bstt_pkg::INDEX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- probe check ----------------
    always_comb
    begin
        rd_entry     = bstt_pkg::entry_t'(ram_rdata);
        rd_score_ext = bstt_pkg::WIDE_W'($signed(rd_entry.score));
        alpha_ext    = bstt_pkg::WIDE_W'($signed(p1_alpha_reg));
        beta_ext     = bstt_pkg::WIDE_W'($signed(p1_beta_reg));

        case (rd_entry.kind)
            bstt_pkg::KIND_EXACT: usable = 1'b1;
            bstt_pkg::KIND_LOWER: usable = (rd_score_ext >= beta_ext);
            bstt_pkg::KIND_UPPER: usable = (rd_score_ext <= alpha_ext);
            default:              usable = 1'b0;
        endcase

        hit = usable && (rd_entry.key == p1_key_reg) &&
              (bstt_pkg::DEPTH_CMP_W'(rd_entry.depth) >=
               bstt_pkg::DEPTH_CMP_W'(p1_depth_reg));

        out_data_next.hit       = hit;
        out_data_next.hit_value = hit ? bstt_pkg::IN_SCORE_W'(rd_score_ext) : '0;
    end

    // ---------------- control next state ----------------
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end

        p1_valid_next = stall || accept_probe;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_idx_reg   <= clr_idx_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_probe)
        begin
            p1_key_reg   <= in_data.position_key;
            p1_depth_reg <= in_data.search_depth;
            p1_alpha_reg <= in_data.alpha_bound;
            p1_beta_reg  <= in_data.beta_bound;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/bstt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
// Testbench for the transposition table: directed bound checks, then random store/probe traffic.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bstt_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 10;
    localparam int POOL_SIZE    = 32;
    localparam int SCORE_HI     = (1 << (SCORE_BITS - 1)) - 1;
    localparam int SCORE_LO     = -(1 << (SCORE_BITS - 1));
    localparam int DEPTH_HI     = (1 << DEPTH_BITS) - 1;

    localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_LOWER = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_UPPER = 2'd2;
    localparam logic [FLAG_W-1:0] FLAG_BAD   = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    bounded_score_transposition_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the table
    kind_t            model_kind  [TABLE_ENTRIES];
    logic [KEY_W-1:0] model_key   [TABLE_ENTRIES];
    int               model_depth [TABLE_ENTRIES];
    int               model_score [TABLE_ENTRIES];

    out_item_t expected_probe_q[$];
    in_item_t  stored_pool[$];
    int        mismatch_count  = 0;
    int        sender_idle_pct = 0;
    int        recv_idle_pct   = 0;
    int        hold_cycles     = 0;
    int        cycle_count     = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_model();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            model_kind[i]  = KIND_EMPTY;
            model_key[i]   = '0;
            model_depth[i] = 0;
            model_score[i] = 0;
        end
    endfunction

    // Apply one accepted transfer to the shadow table; probes queue their result.
    function automatic void predict_access(in_item_t it);
        int                idx;
        int                score;
        int                depth;
        logic [KIND_W-1:0] kind_code;
        logic              hit;
        out_item_t         res;
        idx   = int'(it.position_key[INDEX_BITS-1:0]);
        depth = int'(it.search_depth);
        if (it.action == ACT_STORE)
        begin
            score = int'($signed(it.store_value));
            if (score > SCORE_HI)
                score = SCORE_HI;
            if (score < SCORE_LO)
                score = SCORE_LO;
            // flag 3 wraps to the empty kind
            kind_code        = it.store_flag + 2'd1;
            model_key[idx]   = it.position_key;
            model_depth[idx] = (depth > DEPTH_HI) ? DEPTH_HI : depth;
            model_score[idx] = score;
            model_kind[idx]  = kind_t'(kind_code);
        end
        else
        begin
            hit   = 1'b0;
            score = model_score[idx];
            if (model_kind[idx] != KIND_EMPTY && model_key[idx] == it.position_key &&
                model_depth[idx] >= depth)
            begin
                case (model_kind[idx])
                    KIND_EXACT: hit = 1'b1;
                    KIND_LOWER: hit = (score >= int'($signed(it.beta_bound)));
                    KIND_UPPER: hit = (score <= int'($signed(it.alpha_bound)));
                    default:    hit = 1'b0;
                endcase
            end
            res.hit       = hit;
            res.hit_value = hit ? IN_SCORE_W'(score) : '0;
            expected_probe_q.push_back(res);
        end
    endfunction

    function automatic in_item_t make_item(logic act, logic [KEY_W-1:0] key, int depth,
                                           int alpha, int beta, int value,
                                           logic [FLAG_W-1:0] flag);
        in_item_t it;
        it.action       = act;
        it.position_key = key;
        it.search_depth = IN_DEPTH_W'(depth);
        it.alpha_bound  = IN_SCORE_W'(alpha);
        it.beta_bound   = IN_SCORE_W'(beta);
        it.store_value  = IN_SCORE_W'(value);
        it.store_flag   = flag;
        return it;
    endfunction

    // Mostly stores and probes of recently stored keys, with aliases and noise.
    function automatic in_item_t random_access();
        in_item_t it;
        in_item_t prior;
        int       pick;
        int       score;
        int       depth;
        int       bit_pos;
        it.action       = ACT_PROBE;
        it.position_key = {$urandom, $urandom};
        it.search_depth = IN_DEPTH_W'($urandom_range(DEPTH_HI));
        it.alpha_bound  = IN_SCORE_W'($urandom);
        it.beta_bound   = IN_SCORE_W'($urandom);
        it.store_value  = IN_SCORE_W'($urandom);
        it.store_flag   = ($urandom_range(99) < 8) ? FLAG_BAD : FLAG_W'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            it.action = ACT_STORE;
            if (stored_pool.size() > 0 && $urandom_range(3) == 0)
            begin
                prior = stored_pool[$urandom_range(stored_pool.size() - 1)];
                it.position_key = prior.position_key;
                // sometimes same index, different tag
                if ($urandom_range(1) == 0)
                begin
                    bit_pos = $urandom_range(KEY_W - 1, INDEX_BITS);
                    it.position_key[bit_pos] = ~it.position_key[bit_pos];
                end
            end
            stored_pool.push_back(it);
            if (stored_pool.size() > POOL_SIZE)
                void'(stored_pool.pop_front());
        end
        else if (stored_pool.size() > 0 && pick < 88)
        begin
            prior = stored_pool[$urandom_range(stored_pool.size() - 1)];
            it.position_key = prior.position_key;
            if (pick >= 80)
            begin
                bit_pos = $urandom_range(KEY_W - 1, INDEX_BITS);
                it.position_key[bit_pos] = ~it.position_key[bit_pos];
            end
            depth = int'(prior.search_depth) + int'($urandom_range(2)) - 1;
            if (depth < 0)
                depth = 0;
            if (depth > DEPTH_HI)
                depth = DEPTH_HI;
            it.search_depth = IN_DEPTH_W'(depth);
            score = int'($signed(prior.store_value));
            it.alpha_bound = IN_SCORE_W'(score + int'($urandom_range(4)) - 2);
            it.beta_bound  = IN_SCORE_W'(score + int'($urandom_range(4)) - 2);
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_access(it);
    endtask

    task automatic finish_sending();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_probe_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        sender_idle_pct = 10;
        recv_idle_pct   = 30;
        // cleared entry has key 0 and depth 0 but must still miss
        send_item(make_item(ACT_PROBE, 64'h0, 0, 0, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, '1, DEPTH_HI, SCORE_HI, SCORE_LO, 0, FLAG_EXACT));
        finish_sending();
    endtask

    task automatic test_bound_kinds();
        logic [KEY_W-1:0] key_exact;
        logic [KEY_W-1:0] key_lower;
        logic [KEY_W-1:0] key_upper;
        logic [KEY_W-1:0] key_bad;
        key_exact = 64'hFFFF_FFFF_FFFF_F001;
        key_lower = 64'h0123_4567_89AB_C002;
        key_upper = 64'h8000_0000_0000_0003;
        key_bad   = 64'h5A5A_5A5A_5A5A_5004;
        send_item(make_item(ACT_STORE, key_exact, DEPTH_HI, 0, 0, SCORE_HI, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, key_exact, DEPTH_HI, SCORE_LO, SCORE_HI, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, 64'h7FFF_FFFF_FFFF_F001, 0, 0, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_STORE, key_lower, 10, 0, 0, SCORE_LO, FLAG_LOWER));
        send_item(make_item(ACT_PROBE, key_lower, 10, 0, SCORE_LO, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, key_lower, 10, 0, SCORE_LO + 1, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, key_lower, 11, 0, SCORE_LO, 0, FLAG_EXACT));
        send_item(make_item(ACT_STORE, key_upper, 0, 0, 0, 100, FLAG_UPPER));
        send_item(make_item(ACT_PROBE, key_upper, 0, 100, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, key_upper, 0, 99, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, key_upper, 1, SCORE_HI, 0, 0, FLAG_EXACT));
        // flag code three leaves the entry marked empty
        send_item(make_item(ACT_STORE, key_bad, DEPTH_HI, 0, 0, 5, FLAG_BAD));
        send_item(make_item(ACT_PROBE, key_bad, 0, SCORE_HI, SCORE_LO, 0, FLAG_EXACT));
        send_item(make_item(ACT_STORE, 64'h0, 0, 0, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, 64'h0, 0, 0, 0, 0, FLAG_EXACT));
        finish_sending();
    endtask

    task automatic test_replacement();
        send_item(make_item(ACT_STORE, 64'h0000_0000_0000_1001, 5, 0, 0, -1, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, 64'hFFFF_FFFF_FFFF_F001, 0, 0, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, 64'h0000_0000_0000_1001, 0, 0, 0, 0, FLAG_EXACT));
        send_item(make_item(ACT_PROBE, 64'h0000_0000_0000_1001, 6, 0, 0, 0, FLAG_EXACT));
        finish_sending();
    endtask

    task automatic test_random_traffic(int count, int send_idle, int recv_idle);
        sender_idle_pct = send_idle;
        recv_idle_pct   = recv_idle;
        repeat (count)
            send_item(random_access());
        finish_sending();
    endtask

    // Receiver stops for a long stretch while the sender keeps offering transfers.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_cycles     = 300;
        repeat (40)
            send_item(random_access());
        finish_sending();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready   <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_probe_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result: hit=%0b hit_value=%0d",
                             $time, out_data.hit, out_data.hit_value);
                end
                else
                begin
                    want = expected_probe_q.pop_front();
                    if (want.hit !== out_data.hit)
                    begin
                        mismatch_count++;
                        $display("%0t: hit mismatch: expected %0b, actual %0b",
                                 $time, want.hit, out_data.hit);
                    end
                    if (want.hit_value !== out_data.hit_value)
                    begin
                        mismatch_count++;
                        $display("%0t: hit_value mismatch: expected %0d, actual %0d",
                                 $time, want.hit_value, out_data.hit_value);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, expected_probe_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        clear_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_bound_kinds();
        test_replacement();
        test_random_traffic(600, 26, 76);
        test_backpressure();
        test_random_traffic(600, 76, 26);
        test_random_traffic(600, 0, 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_probe_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
